>>> hw/rtl/ysfm_pkg.sv
`default_nettype none

package ysfm_pkg;

	// Fixed field widths
	localparam int SMP_W  = 12;
	localparam int CHAN_W = 3;
	localparam int MODE_W = 2;
	localparam int LED_W  = 3;
	localparam int THR_W  = 13;
	localparam int PCT_W  = 7;
	localparam int CFG_W  = 12;
	localparam int CFG_IDX_W = 3;

	// Module parameter defaults
	localparam int NUM_CHANNELS_DEF = 8;
	localparam int COUNT_BITS_DEF   = 16;

	// Full-scale sample and percentage scale
	localparam logic [SMP_W-1:0] SMP_FULL = {SMP_W{1'b1}};
	localparam int PCT_FULL = 100;

	// Measure threshold offsets per band
	localparam logic [THR_W-1:0] OFF_LOW  = THR_W'(5);
	localparam logic [THR_W-1:0] OFF_MID  = THR_W'(8);
	localparam logic [THR_W-1:0] OFF_HIGH = THR_W'(10);

	// Operating modes
	typedef enum logic [MODE_W-1:0] {
		MODE_CAL     = 2'd0,
		MODE_CAL_RST = 2'd1,
		MODE_MEASURE = 2'd2,
		MODE_EVAL    = 2'd3
	} mode_t;

	// Indicator codes
	localparam logic [LED_W-1:0] LED_OK    = 3'd0;
	localparam logic [LED_W-1:0] LED_LIGHT = 3'd1;
	localparam logic [LED_W-1:0] LED_HEAVY = 3'd2;
	localparam logic [LED_W-1:0] LED_FLAW  = 3'd3;
	localparam logic [LED_W-1:0] LED_TORN  = 3'd4;
	localparam logic [LED_W-1:0] LED_OOC   = 3'd5;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FLAW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAVY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TORN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MID   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH  = 3'd5;

	typedef struct packed {
		logic [SMP_W-1:0] flaw_level;
		logic [SMP_W-1:0] heavy_dirt_level;
		logic [SMP_W-1:0] light_dirt_level;
		logic [PCT_W-1:0] torn_percent;
		logic [SMP_W-1:0] mid_band_level;
		logic [SMP_W-1:0] high_band_level;
	} cfg_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [CHAN_W-1:0] channel;
		logic [SMP_W-1:0]  sample;
		logic              out_of_circuit;
	} item_t;

	typedef struct packed {
		logic [LED_W-1:0] led_code;
		logic             flaw_flag;
		logic             heavy_dirt_flag;
		logic             light_dirt_flag;
		logic             torn_flag;
		logic [SMP_W-1:0] span;
		logic [THR_W-1:0] perturb_threshold;
	} result_t;

endpackage

`default_nettype wire

>>> hw/rtl/yarn_sensor_fault_monitor.sv
`default_nettype none

// Channel   Handshake                 Payload
// item      item_valid / item_stall   item (item_t)
// result    result_valid / result_stall  result (result_t)
// config    cfg_we                    cfg_index, cfg_data
//
// One item per cycle sustained while the result side does not stall; each
// item is held in the update stage, then its result is registered in the
// output register. The per-channel state memory is read when an item is
// taken, updated in the update stage and written back as that stage advances,
// with a bypass of the write that lands in the same cycle as the read. Reset
// clears the per-entry valid bits at once (no clearing pass) and loads the
// register defaults. A stalled result holds the output register, and the update stage stalls behind it.

module yarn_sensor_fault_monitor import ysfm_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
	parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire item_t                item,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output result_t                   result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam int CH_IDX = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CH_W   = (CH_IDX > CHAN_W) ? CH_IDX : CHAN_W;
	localparam int DATA_W = 4 * SMP_W + 2 * COUNT_BITS;

	cfg_t              cfg_q;
	item_t             item_s1;
	logic              valid_s1;
	logic              in_range_s1;
	logic [CH_IDX-1:0] idx_s1;
	logic              res_valid_q;
	result_t           res_q;

	logic              accept;
	logic              adv_s1;
	logic [CH_W-1:0]   ch_ext;
	logic              in_range;
	logic [DATA_W-1:0] entry, entry_nxt;
	result_t           upd_result;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flaw_level       <= SMP_W'(100);
			cfg_q.heavy_dirt_level <= SMP_W'(500);
			cfg_q.light_dirt_level <= SMP_W'(1300);
			cfg_q.torn_percent     <= PCT_W'(10);
			cfg_q.mid_band_level   <= SMP_W'(900);
			cfg_q.high_band_level  <= SMP_W'(1500);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FLAW:  cfg_q.flaw_level       <= cfg_data[SMP_W-1:0];
				REG_HEAVY: cfg_q.heavy_dirt_level <= cfg_data[SMP_W-1:0];
				REG_LIGHT: cfg_q.light_dirt_level <= cfg_data[SMP_W-1:0];
				REG_TORN:  cfg_q.torn_percent     <= cfg_data[PCT_W-1:0];
				REG_MID:   cfg_q.mid_band_level   <= cfg_data[SMP_W-1:0];
				REG_HIGH:  cfg_q.high_band_level  <= cfg_data[SMP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Handshake: advance the update stage when the output register frees up
	assign adv_s1     = valid_s1 && (!res_valid_q || !result_stall);
	assign item_stall = valid_s1 && !adv_s1;
	assign accept     = item_valid && !item_stall;

	assign ch_ext   = CH_W'(item.channel);
	assign in_range = {1'b0, ch_ext} < (CH_W + 1)'(NUM_CHANNELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold the item while its state is read
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= item;
			in_range_s1 <= in_range;
			idx_s1      <= ch_ext[CH_IDX-1:0];
		end
	end

	ysfm_state_ram #(
		.DEPTH  (NUM_CHANNELS),
		.IDX_W  (CH_IDX),
		.DATA_W (DATA_W)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_idx  (ch_ext[CH_IDX-1:0]),
		.wr_en   (adv_s1 && in_range_s1),
		.wr_idx  (idx_s1),
		.wr_data (entry_nxt),
		.rd_data (entry)
	);

	ysfm_update #(
		.COUNT_BITS (COUNT_BITS),
		.DATA_W     (DATA_W)
	) u_update (
		.item      (item_s1),
		.in_range  (in_range_s1),
		.cfg       (cfg_q),
		.entry     (entry),
		.entry_nxt (entry_nxt),
		.result    (upd_result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= upd_result;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

`default_nettype wire

>>> hw/rtl/ysfm_state_ram.sv
`default_nettype none

module ysfm_state_ram import ysfm_pkg::*; #(
	parameter int DEPTH = NUM_CHANNELS_DEF,
	parameter int IDX_W = 3,
	parameter int DATA_W = 4 * SMP_W + 2 * COUNT_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [IDX_W-1:0]  rd_idx,
	input  wire logic              wr_en,
	input  wire logic [IDX_W-1:0]  wr_idx,
	input  wire logic [DATA_W-1:0] wr_data,
	output logic      [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [DATA_W-1:0] rd_q;
	logic              rd_vld_q;
	logic              byp_q;
	logic [DATA_W-1:0] byp_data_q;

	// Write port; mark entry as holding real data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_idx] <= 1'b1;
		end
	end

	// Registered read; catch a write to the same entry in the same cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q       <= mem[rd_idx];
			rd_vld_q   <= vld_q[rd_idx];
			byp_q      <= wr_en && (wr_idx == rd_idx);
			byp_data_q <= wr_data;
		end
	end

	// Unwritten entries read as zero
	always_comb begin
		if (byp_q) begin
			rd_data = byp_data_q;
		end else if (rd_vld_q) begin
			rd_data = rd_q;
		end else begin
			rd_data = '0;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/ysfm_update.sv
`default_nettype none

module ysfm_update import ysfm_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	parameter int DATA_W = 4 * SMP_W + 2 * COUNT_BITS
) (
	input  wire item_t             item,
	input  wire logic              in_range,
	input  wire cfg_t              cfg,
	input  wire logic [DATA_W-1:0] entry,
	output logic      [DATA_W-1:0] entry_nxt,
	output result_t                result
);

	localparam int PROD_W = COUNT_BITS + PCT_W;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic [SMP_W-1:0]      max_v, min_v, span_v, cal_v;
	logic [COUNT_BITS-1:0] scnt_v, pcnt_v;
	logic [SMP_W-1:0]      max_n, min_n, span_n, cal_n;
	logic [COUNT_BITS-1:0] scnt_n, pcnt_n;
	logic [SMP_W-1:0]      trk_max, trk_min, trk_sp, trk_span;
	logic [THR_W-1:0]      thr;
	logic [COUNT_BITS-1:0] scnt_inc, pcnt_inc;
	logic [PROD_W-1:0]     pcnt_scaled, scnt_scaled;
	logic                  torn;
	logic [SMP_W-1:0]      s;

	assign s = item.sample;
	assign {max_v, min_v, span_v, cal_v, scnt_v, pcnt_v} = entry;

	// Track extremes and the widest span
	always_comb begin
		trk_max  = (s > max_v) ? s : max_v;
		trk_min  = (s < min_v) ? s : min_v;
		trk_sp   = trk_max - trk_min;
		trk_span = (trk_sp > span_v) ? trk_sp : span_v;
	end

	// Band-dependent measure threshold
	always_comb begin
		if (s <= cfg.mid_band_level) begin
			thr = {1'b0, cal_v} + OFF_LOW;
		end else if (s <= cfg.high_band_level) begin
			thr = {1'b0, cal_v} + OFF_MID;
		end else begin
			thr = {1'b0, cal_v} + OFF_HIGH;
		end
	end

	// Saturating counts and exact torn ratio test
	assign scnt_inc    = (scnt_v == CNT_MAX) ? scnt_v : scnt_v + 1'b1;
	assign pcnt_inc    = (pcnt_v == CNT_MAX) ? pcnt_v : pcnt_v + 1'b1;
	assign pcnt_scaled = PROD_W'(pcnt_v) * PROD_W'(PCT_FULL);
	assign scnt_scaled = PROD_W'(cfg.torn_percent) * PROD_W'(scnt_v);
	assign torn        = pcnt_scaled < scnt_scaled;

	always_comb begin
		max_n  = max_v;
		min_n  = min_v;
		span_n = span_v;
		cal_n  = cal_v;
		scnt_n = scnt_v;
		pcnt_n = pcnt_v;
		result = '0;
		case (mode_t'(item.mode))
			MODE_CAL: begin
				max_n  = trk_max;
				min_n  = trk_min;
				span_n = trk_span;
				cal_n  = trk_span;
				result.span = trk_sp;
			end
			MODE_CAL_RST: begin
				max_n  = '0;
				min_n  = SMP_FULL;
				cal_n  = (span_v > cal_v) ? span_v : cal_v;
				span_n = '0;
			end
			MODE_MEASURE: begin
				max_n  = trk_max;
				min_n  = trk_min;
				span_n = trk_span;
				scnt_n = scnt_inc;
				if ({1'b0, trk_sp} > thr) begin
					pcnt_n = pcnt_inc;
				end
				result.span = trk_sp;
				result.perturb_threshold = thr;
			end
			MODE_EVAL: begin
				result.span = (min_v > max_v) ? '0 : max_v - min_v;
				if (s <= cfg.flaw_level || s == SMP_FULL) begin
					result.flaw_flag = 1'b1;
					result.led_code  = LED_FLAW;
				end else if (s <= cfg.heavy_dirt_level) begin
					result.heavy_dirt_flag = 1'b1;
					result.led_code        = LED_HEAVY;
				end else if (torn) begin
					result.torn_flag = 1'b1;
					result.led_code  = LED_TORN;
				end else if (s <= cfg.light_dirt_level) begin
					result.light_dirt_flag = 1'b1;
					result.led_code        = LED_LIGHT;
				end else begin
					result.led_code = LED_OK;
				end
				if (item.out_of_circuit) begin
					result.led_code = LED_OOC;
				end
				max_n  = '0;
				min_n  = SMP_FULL;
				scnt_n = '0;
				pcnt_n = '0;
			end
			default: begin
				result = '0;
			end
		endcase
		// Unknown channel: all-zero result
		if (!in_range) begin
			result = '0;
		end
	end

	assign entry_nxt = {max_n, min_n, span_n, cal_n, scnt_n, pcnt_n};

endmodule

`default_nettype wire

>>> bench/tb_yarn_sensor_fault_monitor.sv
module tb_yarn_sensor_fault_monitor;
	timeunit 1ns;
	timeprecision 1ps;
	import ysfm_pkg::*;

	localparam int NCH          = NUM_CHANNELS_DEF;
	localparam int CNT_W        = COUNT_BITS_DEF;
	localparam int HALF_PERIOD  = 4;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int HOLD_OFF_LEN = 200;
	localparam int SETTLE       = 10;
	localparam int REPORT_MAX   = 10;
	localparam int SAT_RUN      = 16;

	// Per-channel script position for well-formed sequences
	typedef enum int {PLAN_CAL, PLAN_RECAL, PLAN_MEASURE, PLAN_EVAL} plan_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	item_t                item = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	yarn_sensor_fault_monitor i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Items waiting to be offered and reports owed by the block
	item_t   samples_to_send[$];
	result_t reports_due[$];

	// Local copy of the level registers and the per-channel window
	cfg_t cur_cfg = '{12'd100, 12'd500, 12'd1300, 7'd10, 12'd900, 12'd1500};
	logic [SMP_W-1:0] ch_max      [NCH] = '{default: '0};
	logic [SMP_W-1:0] ch_min      [NCH] = '{default: '0};
	logic [SMP_W-1:0] ch_peak     [NCH] = '{default: '0};
	logic [SMP_W-1:0] ch_cal      [NCH] = '{default: '0};
	logic [CNT_W-1:0] ch_samples  [NCH] = '{default: '0};
	logic [CNT_W-1:0] ch_perturbs [NCH] = '{default: '0};

	plan_t plan_stage [NCH];
	int    plan_left  [NCH];
	int    plan_base  [NCH];
	int    plan_amp   [NCH];

	int items_offered = 0;
	int items_accepted = 0;
	int reports_checked = 0;
	int errors = 0;
	int mode_hits [4] = '{default: 0};
	int gap_left = 0;
	int hold_left = 0;
	int free_left = 0;
	bit item_taken = 1'b0;
	bit tx_no_gaps = 1'b0;
	bit rx_stalls_on = 1'b1;
	bit pressure_req = 1'b0;
	bit pressure_done = 1'b0;

	initial begin
		forever #HALF_PERIOD clk = ~clk;
	end

	// Widen the window with one sample and return the current span
	function automatic logic [SMP_W-1:0] track_sample(int c, logic [SMP_W-1:0] s);
		logic [SMP_W-1:0] sp;
		if (s > ch_max[c]) ch_max[c] = s;
		if (s < ch_min[c]) ch_min[c] = s;
		sp = ch_max[c] - ch_min[c];
		if (sp > ch_peak[c]) ch_peak[c] = sp;
		return sp;
	endfunction

	function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Expected report for one item; advances the channel window
	function automatic result_t yarn_report(item_t it);
		result_t          r;
		logic [SMP_W-1:0] s;
		logic [SMP_W-1:0] sp;
		logic [THR_W-1:0] thr;
		logic             torn;
		int               c;
		r = '0;
		s = it.sample;
		c = it.channel;
		case (mode_t'(it.mode))
		MODE_CAL: begin
			r.span = track_sample(c, s);
			ch_cal[c] = ch_peak[c];
		end
		MODE_CAL_RST: begin
			ch_max[c] = '0;
			ch_min[c] = SMP_FULL;
			if (ch_peak[c] > ch_cal[c]) ch_cal[c] = ch_peak[c];
			ch_peak[c] = '0;
		end
		MODE_MEASURE: begin
			if (s <= cur_cfg.mid_band_level) thr = THR_W'(ch_cal[c]) + OFF_LOW;
			else if (s <= cur_cfg.high_band_level) thr = THR_W'(ch_cal[c]) + OFF_MID;
			else thr = THR_W'(ch_cal[c]) + OFF_HIGH;
			sp = track_sample(c, s);
			r.span = sp;
			r.perturb_threshold = thr;
			ch_samples[c] = bump(ch_samples[c]);
			if (THR_W'(sp) > thr) ch_perturbs[c] = bump(ch_perturbs[c]);
		end
		MODE_EVAL: begin
			torn = (64'(ch_perturbs[c]) * 64'(PCT_FULL)) <
			       (64'(cur_cfg.torn_percent) * 64'(ch_samples[c]));
			r.span = (ch_min[c] > ch_max[c]) ? '0 : ch_max[c] - ch_min[c];
			if (s <= cur_cfg.flaw_level || s == SMP_FULL) begin
				r.flaw_flag = 1'b1;
				r.led_code = LED_FLAW;
			end else if (s <= cur_cfg.heavy_dirt_level) begin
				r.heavy_dirt_flag = 1'b1;
				r.led_code = LED_HEAVY;
			end else if (torn) begin
				r.torn_flag = 1'b1;
				r.led_code = LED_TORN;
			end else if (s <= cur_cfg.light_dirt_level) begin
				r.light_dirt_flag = 1'b1;
				r.led_code = LED_LIGHT;
			end
			if (it.out_of_circuit) r.led_code = LED_OOC;
			// Clear the window, keep the calibration
			ch_max[c] = '0;
			ch_min[c] = SMP_FULL;
			ch_samples[c] = '0;
			ch_perturbs[c] = '0;
		end
		default: ;
		endcase
		return r;
	endfunction

	function automatic string describe(result_t r);
		return $sformatf("led=%0d flaw=%b heavy=%b light=%b torn=%b span=%0d thr=%0d",
			r.led_code, r.flaw_flag, r.heavy_dirt_flag, r.light_dirt_flag,
			r.torn_flag, r.span, r.perturb_threshold);
	endfunction

	// Mostly back-to-back, sometimes short gaps, rarely long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (tx_no_gaps || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	// Offer the next item at the falling edge; hold one that was not taken
	always @(negedge clk) begin
		item_t nxt_item;
		logic  nxt_valid;
		nxt_item = item;
		nxt_valid = item_valid;
		if (arst_n && !(item_valid && !item_taken)) begin
			if (gap_left > 0) begin
				nxt_valid = 1'b0;
				gap_left--;
			end else if (samples_to_send.size() != 0) begin
				nxt_item = samples_to_send.pop_front();
				nxt_valid = 1'b1;
				items_offered++;
				gap_left = pick_gap();
			end else begin
				nxt_valid = 1'b0;
			end
		end
		item_valid <= nxt_valid;
		item <= nxt_item;
	end

	// Receiver back-pressure: random bursts, plus one long hold-off on request
	always @(negedge clk) begin
		logic nxt_stall;
		nxt_stall = 1'b0;
		if (!arst_n) begin
			nxt_stall = 1'b0;
		end else if (hold_left > 0) begin
			nxt_stall = 1'b1;
			hold_left--;
		end else if (pressure_req && !pressure_done) begin
			pressure_done = 1'b1;
			hold_left = HOLD_OFF_LEN - 1;
			nxt_stall = 1'b1;
		end else if (rx_stalls_on) begin
			if (free_left > 0) begin
				free_left--;
			end else begin
				nxt_stall = 1'b1;
				hold_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
				                                         : $urandom_range(6, 30);
				free_left = $urandom_range(0, 10);
			end
		end
		result_stall <= nxt_stall;
	end

	// Track register writes, predict taken items, check returned reports
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
				REG_FLAW:  cur_cfg.flaw_level = cfg_data;
				REG_HEAVY: cur_cfg.heavy_dirt_level = cfg_data;
				REG_LIGHT: cur_cfg.light_dirt_level = cfg_data;
				REG_TORN:  cur_cfg.torn_percent = cfg_data[PCT_W-1:0];
				REG_MID:   cur_cfg.mid_band_level = cfg_data;
				REG_HIGH:  cur_cfg.high_band_level = cfg_data;
				default: ;
				endcase
			end
			if (item_valid && !item_stall) begin
				reports_due.push_back(yarn_report(item));
				items_accepted++;
				mode_hits[item.mode]++;
			end
			if (result_valid && !result_stall) begin
				if (reports_due.size() == 0) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display("unexpected result at %0t: %s", $realtime, describe(result));
				end else begin
					want = reports_due.pop_front();
					reports_checked++;
					if (result.led_code !== want.led_code ||
					    result.flaw_flag !== want.flaw_flag ||
					    result.heavy_dirt_flag !== want.heavy_dirt_flag ||
					    result.light_dirt_flag !== want.light_dirt_flag ||
					    result.torn_flag !== want.torn_flag ||
					    result.span !== want.span ||
					    result.perturb_threshold !== want.perturb_threshold) begin
						errors++;
						if (errors <= REPORT_MAX)
							$display("mismatch on result %0d\n  expected %s\n  actual   %s",
								reports_checked, describe(want), describe(result));
					end
				end
			end
		end
		item_taken <= arst_n && item_valid && !item_stall;
	end

	function automatic logic [SMP_W-1:0] jitter(int centre, int amp);
		int v;
		v = centre + int'($urandom_range(0, 2 * amp)) - amp;
		if (v < 0) v = 0;
		if (v > int'(SMP_FULL)) v = SMP_FULL;
		return SMP_W'(v);
	endfunction

	function automatic void send_item(mode_t m, int ch, int smp, bit ooc);
		item_t it;
		it.mode = m;
		it.channel = CHAN_W'(ch);
		it.sample = SMP_W'(smp);
		it.out_of_circuit = ooc;
		samples_to_send.push_back(it);
	endfunction

	// Start a fresh calibration round around a new level
	function automatic void restart_plan(int c);
		plan_stage[c] = PLAN_CAL;
		plan_left[c] = $urandom_range(2, 6);
		case ($urandom_range(0, 3))
		0: plan_base[c] = jitter(cur_cfg.mid_band_level, 40);
		1: plan_base[c] = jitter(cur_cfg.high_band_level, 40);
		default: plan_base[c] = $urandom_range(0, SMP_FULL);
		endcase
	endfunction

	function automatic void arm_measure(int c);
		plan_stage[c] = PLAN_MEASURE;
		plan_left[c] = $urandom_range(3, 20);
		plan_amp[c] = $urandom_range(0, 80);
	endfunction

	// Evaluate samples cluster on the class borders and the rails
	function automatic logic [SMP_W-1:0] eval_sample();
		case ($urandom_range(0, 5))
		0: return jitter(cur_cfg.flaw_level, 1);
		1: return jitter(cur_cfg.heavy_dirt_level, 1);
		2: return jitter(cur_cfg.light_dirt_level, 1);
		3: return SMP_FULL;
		4: return '0;
		default: return SMP_W'($urandom);
		endcase
	endfunction

	// Next step of a calibrate, measure, evaluate cycle on one channel
	function automatic item_t plan_item(int c);
		item_t it;
		it.channel = CHAN_W'(c);
		it.out_of_circuit = 1'b0;
		case (plan_stage[c])
		PLAN_CAL: begin
			it.mode = MODE_CAL;
			it.sample = jitter(plan_base[c], 25);
			plan_left[c]--;
			if (plan_left[c] <= 0) begin
				if ($urandom_range(0, 3) == 0) plan_stage[c] = PLAN_RECAL;
				else arm_measure(c);
			end
		end
		PLAN_RECAL: begin
			it.mode = MODE_CAL_RST;
			it.sample = SMP_W'($urandom);
			restart_plan(c);
		end
		PLAN_MEASURE: begin
			it.mode = MODE_MEASURE;
			it.sample = jitter(plan_base[c], plan_amp[c]);
			plan_left[c]--;
			if (plan_left[c] <= 0) plan_stage[c] = PLAN_EVAL;
		end
		default: begin
			it.mode = MODE_EVAL;
			it.sample = eval_sample();
			it.out_of_circuit = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 1) == 0) arm_measure(c);
			else restart_plan(c);
		end
		endcase
		return it;
	endfunction

	// Mostly scripted sequences across channels, the rest raw noise
	task automatic queue_random(int n);
		item_t it;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 99) < 78) begin
				it = plan_item($urandom_range(0, NCH - 1));
			end else begin
				it = item_t'($urandom);
			end
			samples_to_send.push_back(it);
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (samples_to_send.size() != 0 || items_offered != items_accepted ||
		       reports_due.size() != 0);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	// Reprogram every level once the block has drained
	task automatic program_levels(cfg_t v);
		wait_idle();
		repeat (4) @(negedge clk);
		write_reg(REG_FLAW, v.flaw_level);
		write_reg(REG_HEAVY, v.heavy_dirt_level);
		write_reg(REG_LIGHT, v.light_dirt_level);
		write_reg(REG_TORN, CFG_W'(v.torn_percent));
		write_reg(REG_MID, v.mid_band_level);
		write_reg(REG_HIGH, v.high_band_level);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		for (int cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk);
		$display("timeout after %0d cycles, %0d reports outstanding",
			CYCLE_LIMIT, reports_due.size());
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		cfg_t lv;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int c = 0; c < NCH; c++) restart_plan(c);

		// Directed: untouched channels, full-scale span, band edges, each class
		send_item(MODE_EVAL, 0, 0, 1'b1);
		send_item(MODE_EVAL, 0, SMP_FULL, 1'b0);
		send_item(MODE_CAL, 1, SMP_FULL, 1'b0);
		send_item(MODE_CAL, 1, 0, 1'b0);
		send_item(MODE_CAL_RST, 1, 0, 1'b0);
		send_item(MODE_CAL, 1, 2000, 1'b0);
		send_item(MODE_CAL, 1, 2012, 1'b0);
		send_item(MODE_MEASURE, 1, 900, 1'b0);
		send_item(MODE_MEASURE, 1, 901, 1'b0);
		send_item(MODE_MEASURE, 1, 1500, 1'b0);
		send_item(MODE_MEASURE, 1, 1501, 1'b0);
		send_item(MODE_MEASURE, 1, SMP_FULL, 1'b0);
		send_item(MODE_EVAL, 1, 1300, 1'b0);
		send_item(MODE_CAL_RST, 3, 0, 1'b0);
		send_item(MODE_MEASURE, 3, 2000, 1'b0);
		send_item(MODE_MEASURE, 3, 2000, 1'b0);
		send_item(MODE_MEASURE, 3, 2000, 1'b0);
		send_item(MODE_EVAL, 3, 2000, 1'b0);
		send_item(MODE_EVAL, 4, 500, 1'b0);
		send_item(MODE_EVAL, 5, 501, 1'b0);
		send_item(MODE_EVAL, 6, 101, 1'b0);
		send_item(MODE_EVAL, 7, 100, 1'b0);
		send_item(MODE_EVAL, 7, 1301, 1'b1);
		send_item(MODE_MEASURE, 6, SMP_FULL, 1'b0);
		queue_random(200);

		// All levels at the floor
		program_levels('0);
		queue_random(150);

		// All levels at the top; sender runs flat out into a long hold-off
		lv = '{SMP_FULL, SMP_FULL, SMP_FULL, PCT_W'(PCT_FULL), SMP_FULL, SMP_FULL};
		program_levels(lv);
		tx_no_gaps = 1'b1;
		pressure_req = 1'b1;
		queue_random(150);

		// Ordered random levels
		lv.flaw_level = SMP_W'($urandom_range(0, 400));
		lv.heavy_dirt_level = SMP_W'($urandom_range(lv.flaw_level, 1500));
		lv.light_dirt_level = SMP_W'($urandom_range(lv.heavy_dirt_level, 3000));
		lv.torn_percent = PCT_W'($urandom_range(0, PCT_FULL));
		lv.mid_band_level = SMP_W'($urandom_range(0, 2500));
		lv.high_band_level = SMP_W'($urandom_range(lv.mid_band_level, SMP_FULL));
		program_levels(lv);
		tx_no_gaps = 1'b0;
		queue_random(200);

		// Unordered random levels, receiver never stalls
		lv.flaw_level = SMP_W'($urandom);
		lv.heavy_dirt_level = SMP_W'($urandom);
		lv.light_dirt_level = SMP_W'($urandom);
		lv.torn_percent = PCT_W'($urandom_range(0, PCT_FULL));
		lv.mid_band_level = SMP_W'($urandom);
		lv.high_band_level = SMP_W'($urandom);
		program_levels(lv);
		rx_stalls_on = 1'b0;
		queue_random(200);

		// Flat-out run of rail-to-rail measures on one channel
		wait_idle();
		tx_no_gaps = 1'b1;
		send_item(MODE_CAL_RST, NCH - 1, 0, 1'b0);
		send_item(MODE_CAL, NCH - 1, 0, 1'b0);
		send_item(MODE_EVAL, NCH - 1, 2000, 1'b0);
		for (int k = 0; k < SAT_RUN; k++)
			send_item(MODE_MEASURE, NCH - 1, (k % 2) ? SMP_FULL : 0, 1'b0);
		send_item(MODE_EVAL, NCH - 1, 2000, 1'b0);
		send_item(MODE_EVAL, NCH - 1, 2000, 1'b0);

		wait_idle();
		repeat (SETTLE) @(posedge clk);
		$display("sent %0d items on %0d channels: %0d calibrate, %0d recalibrate,",
			items_accepted, NCH, mode_hits[MODE_CAL], mode_hits[MODE_CAL_RST]);
		$display("  %0d measure, %0d evaluate; checked %0d reports over five level settings",
			mode_hits[MODE_MEASURE], mode_hits[MODE_EVAL], reports_checked);
		$display("  and a %0d-cycle hold-off; %0d errors", HOLD_OFF_LEN, errors);
		if (errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule
